### design/tsq_pkg.sv
// ----------------------------------------------------------------------------
// tsq_pkg: shared types and constants of the think time sorted queue
// Sizes of the queue, status codes and the record held by one cell.
// ----------------------------------------------------------------------------
package tsq_pkg;

	localparam int DEPTH    = 32;
	localparam int KEY_BITS = 32;
	localparam int TAG_BITS = 16;
	localparam int CNT_BITS = $clog2(DEPTH + 1);

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_POP    = 1'b1;

	typedef logic [KEY_BITS-1:0] key_t;
	typedef logic [TAG_BITS-1:0] tag_t;
	typedef logic [CNT_BITS-1:0] cnt_t;

	// one stored entry
	typedef struct packed {
		logic valid;
		key_t key;
		tag_t tag;
	} entry_t;

	// operation broadcast to every cell in a cycle
	typedef struct packed {
		logic insert;
		logic pop;
		key_t key;
		tag_t tag;
	} cell_cmd_t;

endpackage

### design/tsq_in_if.sv
// ----------------------------------------------------------------------------
// tsq_in_if: request channel of the sorted queue
// Carries an insert or pop request with its key and tag.
// ----------------------------------------------------------------------------
interface tsq_in_if;
	import tsq_pkg::*;

	logic valid;
	logic ready;
	logic action;
	key_t key;
	tag_t tag;

	modport source (output valid, output action, output key, output tag, input ready);
	modport sink (input valid, input action, input key, input tag, output ready);
endinterface

### design/tsq_out_if.sv
// ----------------------------------------------------------------------------
// tsq_out_if: result channel of the sorted queue
// Carries the status, popped entry and occupancy of one request.
// ----------------------------------------------------------------------------
interface tsq_out_if;
	import tsq_pkg::*;

	logic       valid;
	logic       ready;
	logic [1:0] status;
	key_t       out_key;
	tag_t       out_tag;
	cnt_t       occupancy;

	modport source (output valid, output status, output out_key, output out_tag,
		output occupancy, input ready);
	modport sink (input valid, input status, input out_key, input out_tag,
		input occupancy, output ready);
endinterface

### design/tsq_cell.sv
// ----------------------------------------------------------------------------
// tsq_cell: one slot of the sorted queue
// Holds one entry, decides locally whether to keep it, take the new entry,
// take its left neighbor on an insert or its right neighbor on a pop.
// ----------------------------------------------------------------------------
module tsq_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  tsq_pkg::cell_cmd_t cmd,
	input  tsq_pkg::entry_t    left_entry,
	input  logic               left_ge,
	input  tsq_pkg::entry_t    right_entry,
	output tsq_pkg::entry_t    entry,
	output logic               ge
);
	import tsq_pkg::*;

	logic valid_q;
	key_t key_q;
	tag_t tag_q;

	// new key goes in front of this slot: slot empty or key not smaller
	assign ge    = !valid_q || (key_q >= cmd.key);
	assign entry = '{valid: valid_q, key: key_q, tag: tag_q};

	// occupancy of the slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.insert) begin
			if (left_ge) begin
				valid_q <= left_entry.valid;
			end else if (ge) begin
				valid_q <= 1'b1;
			end
		end else if (cmd.pop) begin
			valid_q <= right_entry.valid;
		end
	end

	// payload: shift right, load, or shift left
	always_ff @(posedge clk) begin
		if (cmd.insert) begin
			if (left_ge) begin
				key_q <= left_entry.key;
				tag_q <= left_entry.tag;
			end else if (ge) begin
				key_q <= cmd.key;
				tag_q <= cmd.tag;
			end
		end else if (cmd.pop) begin
			key_q <= right_entry.key;
			tag_q <= right_entry.tag;
		end
	end

endmodule

### design/think_time_sorted_queue.sv
// ----------------------------------------------------------------------------
// think_time_sorted_queue: bounded priority queue in ascending key order
// Row of cells that insert in sorted place and pop from the front.
// ----------------------------------------------------------------------------
// Usage
//   in_ch carries requests: action 0 inserts (key, tag), action 1 pops the
//   entry with the smallest key; key and tag are ignored on a pop. Among
//   equal keys the most recently inserted entry leaves first.
//   out_ch returns one result per request: status (done, insert dropped
//   because full, pop on empty), the popped key and tag (zero otherwise)
//   and the occupancy after the request.
//   The result is valid in the cycle after the request transfer. Throughput
//   is one request per cycle while the receiver takes each result, since every
//   cell compares its key with the new key in parallel and each cell
//   updates from itself, its neighbor or the request.
//   The result sits in an output register; while the receiver stalls it is
//   held and in_ch.ready is low, and ready returns in the cycle the result
//   is taken, so back to back transfers continue without a gap.
//   Reset empties the queue at once (all slot valid bits cleared) and
//   drops any pending result; no clearing pass is needed.
// ----------------------------------------------------------------------------
module think_time_sorted_queue (
	input  logic      clk,
	input  logic      arst_n,
	tsq_in_if.sink    in_ch,
	tsq_out_if.source out_ch
);
	import tsq_pkg::*;

	localparam cnt_t DEPTH_CNT = CNT_BITS'(DEPTH);

	cnt_t       count_q;
	logic       out_valid_q;
	logic [1:0] status_q;
	key_t       out_key_q;
	tag_t       out_tag_q;
	cnt_t       occupancy_q;

	logic      in_xfer;
	logic      do_insert;
	logic      do_pop;
	cell_cmd_t cmd;

	entry_t           cells[DEPTH];
	logic             ge_vec[DEPTH];
	logic [DEPTH-1:0] valid_vec;

	// request transfer and operation decode
	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign in_xfer     = in_ch.valid && in_ch.ready;
	assign do_insert   = in_xfer && (in_ch.action == ACT_INSERT) && (count_q != DEPTH_CNT);
	assign do_pop      = in_xfer && (in_ch.action == ACT_POP) && (count_q != '0);
	assign cmd         = '{insert: do_insert, pop: do_pop, key: in_ch.key, tag: in_ch.tag};

	// row of cells, slot 0 holds the smallest key
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		entry_t left_e;
		logic   left_g;
		entry_t right_e;

		if (i == 0) begin : g_first
			assign left_e = '0;
			assign left_g = 1'b0;
		end else begin : g_mid_l
			assign left_e = cells[i-1];
			assign left_g = ge_vec[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_e = '0;
		end else begin : g_mid_r
			assign right_e = cells[i+1];
		end

		tsq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.left_entry (left_e),
			.left_ge    (left_g),
			.right_entry(right_e),
			.entry      (cells[i]),
			.ge         (ge_vec[i])
		);

		assign valid_vec[i] = cells[i].valid;
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (do_insert) begin
			count_q <= count_q + cnt_t'(1);
		end else if (do_pop) begin
			count_q <= count_q - cnt_t'(1);
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ch.ready) begin
			out_valid_q <= in_ch.valid;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			out_key_q <= '0;
			out_tag_q <= '0;
			status_q  <= ST_DONE;
			if (in_ch.action == ACT_INSERT) begin
				if (count_q == DEPTH_CNT) begin
					status_q    <= ST_FULL;
					occupancy_q <= count_q;
				end else begin
					occupancy_q <= count_q + cnt_t'(1);
				end
			end else begin
				if (count_q == '0) begin
					status_q    <= ST_EMPTY;
					occupancy_q <= count_q;
				end else begin
					out_key_q   <= cells[0].key;
					out_tag_q   <= cells[0].tag;
					occupancy_q <= count_q - cnt_t'(1);
				end
			end
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.status    = status_q;
	assign out_ch.out_key   = out_key_q;
	assign out_ch.out_tag   = out_tag_q;
	assign out_ch.occupancy = occupancy_q;

`ifndef SYNTHESIS
	// occupied slots form a prefix of the row
	a_valid_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot({1'b0, valid_vec} + (DEPTH + 1)'(1)))
		else $error("occupied slots are not contiguous from the front");

	// counter matches the occupied slots
	a_count_match: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == int'(count_q))
		else $error("entry count disagrees with slot valid bits");

	// a pop of a non-empty queue returns the front entry
	a_pop_front: assert property (@(posedge clk) disable iff (!arst_n)
		do_pop |=> (out_key_q == $past(cells[0].key)) && (status_q == ST_DONE))
		else $error("pop did not return the front entry");

	// front two entries stay ordered
	a_front_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		cells[1].valid |-> (cells[0].key <= cells[1].key))
		else $error("front entries out of key order");
`endif

endmodule

### tb/sv/think_time_sorted_queue_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// think_time_sorted_queue_checker: scoreboard of the sorted queue
// Keeps its own sorted copy of the queue and updates it on every request
// transfer. Each result transfer is compared with the oldest expected result.
// ----------------------------------------------------------------------------
module think_time_sorted_queue_checker
	import tsq_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	tsq_in_if    in_ch,
	tsq_out_if   out_ch,
	output int   fail_count,
	output int   outstanding,
	output int   inserts_kept,
	output int   inserts_dropped,
	output int   pops_served,
	output int   pops_on_empty,
	output int   peak_occupancy
);

	// one expected result of a request
	typedef struct packed {
		logic [1:0] status;
		key_t       out_key;
		tag_t       out_tag;
		cnt_t       occupancy;
	} queue_result_t;

	// shadow copy of the sorted entries
	key_t sorted_keys [DEPTH];
	tag_t sorted_tags [DEPTH];
	int   entry_total;

	queue_result_t pending_results [$];
	int            result_index;

	// apply one request to the shadow queue and return what the block must answer
	function automatic queue_result_t apply_request(input logic act, input key_t k,
		input tag_t t);
		queue_result_t r;
		int slot;
		r = '0;
		r.status = ST_DONE;
		if (act == ACT_INSERT) begin
			if (entry_total >= DEPTH) begin
				r.status = ST_FULL;
				inserts_dropped++;
			end else begin
				// new entry goes in front of the first key that is not smaller
				slot = 0;
				while (slot < entry_total && sorted_keys[slot] < k)
					slot++;
				for (int i = entry_total; i > slot; i--) begin
					sorted_keys[i] = sorted_keys[i-1];
					sorted_tags[i] = sorted_tags[i-1];
				end
				sorted_keys[slot] = k;
				sorted_tags[slot] = t;
				entry_total++;
				inserts_kept++;
			end
		end else begin
			if (entry_total == 0) begin
				r.status = ST_EMPTY;
				pops_on_empty++;
			end else begin
				r.out_key = sorted_keys[0];
				r.out_tag = sorted_tags[0];
				for (int i = 1; i < entry_total; i++) begin
					sorted_keys[i-1] = sorted_keys[i];
					sorted_tags[i-1] = sorted_tags[i];
				end
				entry_total--;
				pops_served++;
			end
		end
		if (entry_total > peak_occupancy)
			peak_occupancy = entry_total;
		r.occupancy = cnt_t'(entry_total);
		return r;
	endfunction

	task automatic report_failure(input string msg);
		$display("[%0t] result %0d: %s", $time, result_index, msg);
		fail_count++;
	endtask

	// follow both channels
	always @(posedge clk or negedge arst_n) begin
		queue_result_t want;
		if (!arst_n) begin
			entry_total = 0;
			pending_results.delete();
			result_index = 0;
			fail_count = 0;
			inserts_kept = 0;
			inserts_dropped = 0;
			pops_served = 0;
			pops_on_empty = 0;
			peak_occupancy = 0;
			outstanding <= 0;
		end else begin
			// compare a result transfer with the oldest expectation
			if (out_ch.valid && out_ch.ready) begin
				if (pending_results.size() == 0) begin
					report_failure("result with no request waiting");
				end else begin
					want = pending_results.pop_front();
					if (out_ch.status !== want.status)
						report_failure($sformatf("status got %0d expected %0d",
							out_ch.status, want.status));
					if (out_ch.out_key !== want.out_key)
						report_failure($sformatf("out_key got 0x%08h expected 0x%08h",
							out_ch.out_key, want.out_key));
					if (out_ch.out_tag !== want.out_tag)
						report_failure($sformatf("out_tag got 0x%04h expected 0x%04h",
							out_ch.out_tag, want.out_tag));
					if (out_ch.occupancy !== want.occupancy)
						report_failure($sformatf("occupancy got %0d expected %0d",
							out_ch.occupancy, want.occupancy));
				end
				result_index++;
			end
			// predict the answer to a request transfer
			if (in_ch.valid && in_ch.ready)
				pending_results.push_back(apply_request(in_ch.action, in_ch.key, in_ch.tag));
			outstanding <= pending_results.size();
		end
	end

endmodule

### tb/sv/think_time_sorted_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// think_time_sorted_queue_tb: top of the sorted queue testbench
// Drives directed and random insert and pop requests with random idling on
// both channels and one long receiver hold-off, and reports the verdict of
// the scoreboard.
// ----------------------------------------------------------------------------
module think_time_sorted_queue_tb;
	import tsq_pkg::*;

	localparam int IDLE_LIMIT       = 2000;
	localparam int RANDOM_ITEMS     = 1930;
	localparam int QUIET_TAIL       = 300;
	localparam int PRESSURE_AT      = 700;
	localparam int PRESSURE_INSERTS = 45;
	localparam int HOLD_CYCLES      = 96;

	logic clk;
	logic arst_n;
	logic hold_off_req;
	logic calm;

	int fail_count;
	int outstanding;
	int inserts_kept;
	int inserts_dropped;
	int pops_served;
	int pops_on_empty;
	int peak_occupancy;
	int idle_cycles;
	int sent;

	tsq_in_if  in_ch ();
	tsq_out_if out_ch ();

	think_time_sorted_queue dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	think_time_sorted_queue_checker scoreboard (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_ch           (in_ch),
		.out_ch          (out_ch),
		.fail_count      (fail_count),
		.outstanding     (outstanding),
		.inserts_kept    (inserts_kept),
		.inserts_dropped (inserts_dropped),
		.pops_served     (pops_served),
		.pops_on_empty   (pops_on_empty),
		.peak_occupancy  (peak_occupancy)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// key picker biased to extremes and to a narrow band so equal keys are common
	function automatic key_t pick_key();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2, 3, 4: return key_t'($urandom_range(0, 15));
			5: return '1 - key_t'($urandom_range(0, 15));
			default: return key_t'($urandom);
		endcase
	endfunction

	// offer one request and hold it until the transfer, then maybe idle
	task automatic issue(input logic act, input key_t k, input tag_t t, input bit gaps);
		in_ch.valid  <= 1'b1;
		in_ch.action <= act;
		in_ch.key    <= k;
		in_ch.tag    <= t;
		do @(posedge clk); while (!in_ch.ready);
		sent++;
		if (gaps && $urandom_range(0, 3) == 0) begin
			in_ch.valid <= 1'b0;
			in_ch.key   <= key_t'($urandom);
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	// receiver: short random stalls, one long hold-off on request
	initial begin
		int  stall_left;
		bit  hold_taken;
		stall_left = 0;
		hold_taken = 0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				out_ch.ready <= 1'b0;
				stall_left--;
			end else if (hold_off_req && !hold_taken) begin
				out_ch.ready <= 1'b0;
				stall_left = HOLD_CYCLES - 1;
				hold_taken = 1;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				out_ch.ready <= 1'b0;
				stall_left = $urandom_range(0, 2);
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// watchdog on cycles without any transfer
	initial begin
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

	// stimulus and verdict
	initial begin
		int phase_len;
		int insert_pct;
		int n;
		bit gaps_on;
		bit quiet;
		bit pressure_done;
		in_ch.valid  <= 1'b0;
		in_ch.action <= ACT_INSERT;
		in_ch.key    <= '0;
		in_ch.tag    <= '0;
		arst_n       <= 1'b0;
		hold_off_req <= 1'b0;
		calm         <= 1'b0;
		sent = 0;
		quiet = 0;
		pressure_done = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: pop on empty, key and tag extremes, equal keys, drain past empty
		issue(ACT_POP,    '1,            '1,         1);
		issue(ACT_INSERT, '0,            '0,         1);
		issue(ACT_INSERT, '1,            '1,         1);
		issue(ACT_INSERT, 32'h0001_8000, 16'h1234,   1);
		issue(ACT_INSERT, 32'h0001_8000, 16'h5678,   1);
		issue(ACT_INSERT, 32'h0001_8000, 16'habcd,   1);
		issue(ACT_INSERT, '0,            '1,         1);
		issue(ACT_INSERT, '1,            16'h0001,   1);
		repeat (8) issue(ACT_POP, key_t'($urandom), tag_t'($urandom), 1);
		issue(ACT_INSERT, 32'h5555_5555, 16'haaaa,   1);
		issue(ACT_INSERT, 32'haaaa_aaaa, 16'h5555,   1);
		issue(ACT_POP,    32'h5555_5555, 16'h5555,   1);
		issue(ACT_POP,    '0,            '0,         1);

		// random phases that lean toward filling, mixing or draining
		n = 0;
		while (n < RANDOM_ITEMS) begin
			// long receiver hold-off while inserts keep coming and fill the queue
			if (n >= PRESSURE_AT && !pressure_done) begin
				hold_off_req <= 1'b1;
				pressure_done = 1;
				repeat (PRESSURE_INSERTS) begin
					issue(ACT_INSERT, pick_key(), tag_t'($urandom), 0);
					n++;
				end
			end
			if (n >= RANDOM_ITEMS - QUIET_TAIL) begin
				quiet = 1;
				calm <= 1'b1;
			end
			phase_len = $urandom_range(20, 60);
			case ($urandom_range(0, 2))
				0: insert_pct = 85;
				1: insert_pct = 50;
				default: insert_pct = 15;
			endcase
			gaps_on = !quiet && ($urandom_range(0, 2) != 0);
			for (int i = 0; i < phase_len && n < RANDOM_ITEMS; i++) begin
				if ($urandom_range(1, 100) <= insert_pct)
					issue(ACT_INSERT, pick_key(), tag_t'($urandom), gaps_on);
				else
					issue(ACT_POP, key_t'($urandom), tag_t'($urandom), gaps_on);
				n++;
			end
		end

		// drain remaining results
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (3) @(posedge clk);

		$display("covered %0d requests: %0d inserts kept, %0d dropped when full,",
			sent, inserts_kept, inserts_dropped);
		$display("%0d pops served, %0d pops on empty, peak occupancy %0d, %0d mismatches",
			pops_served, pops_on_empty, peak_occupancy, fail_count);
		if (fail_count == 0 && outstanding == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
